/* rtl/core/bpss_pkg.sv */
// Shared types and constants for the banked port slot scheduler.
package bpss_pkg;

    localparam int ADDR_W     = 32;
    localparam int NOW_W      = 40;
    localparam int SLOT_W     = 48;
    localparam int DELAY_W    = 40;
    localparam int WANT_W     = 45;
    localparam int PORT_W     = 5;
    localparam int LAT_W      = 8;
    localparam int ILV_W      = 16;
    localparam int BANK_OUT_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIV_CNT_W  = 5;

    localparam logic [DIV_CNT_W-1:0] DIV_ADDR_PAIRS = 5'd16;
    localparam logic [DIV_CNT_W-1:0] DIV_WAIT_PAIRS = 5'd24;

    localparam logic [SLOT_W-1:0]  SLOT_MAX  = {SLOT_W{1'b1}};
    localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_RD_PORTS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_PORTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RD_LAT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WR_LAT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ILV      = 3'd4;

    typedef struct packed {
        logic                 start;
        logic [SLOT_W-1:0]    dividend;
        logic [ILV_W-1:0]     divisor;
        logic [DIV_CNT_W-1:0] pairs;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [SLOT_W-1:0] quot;
    } t_div_rsp;

endpackage

/* rtl/core/banked_port_slot_scheduler.sv */
// Steps: bank division, slot update, wait division if the wait needs one, then the output.
// One access at a time: the next transfer can be taken in the cycle after the result registers;
// the shared radix-4 divider takes 16 steps for the bank and 24 for the wait.
// Slot counters live in one RAM read, updated and written back once per access.
// Synchronous active-low reset: config registers to 1, RAM entry valid bits cleared,
// so every slot counter reads as zero; no clearing pass.
module banked_port_slot_scheduler #(
    parameter int BANKS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bpss_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bpss_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_kind,
    input  logic [bpss_pkg::ADDR_W-1:0]         i_addr,
    input  logic [bpss_pkg::NOW_W-1:0]          i_now,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [bpss_pkg::BANK_OUT_W-1:0]     o_bank_index,
    output logic [bpss_pkg::DELAY_W-1:0]        o_delay
);

    localparam int RW    = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int AW    = RW + 1;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BANK = 3'd1;
    localparam logic [2:0] S_RMW  = 3'd2;
    localparam logic [2:0] S_WDIV = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]                      r_state;
    logic [2:0]                      n_state;
    logic [bpss_pkg::PORT_W-1:0]     r_rd_ports;
    logic [bpss_pkg::PORT_W-1:0]     r_wr_ports;
    logic [bpss_pkg::LAT_W-1:0]      r_rd_lat;
    logic [bpss_pkg::LAT_W-1:0]      r_wr_lat;
    logic [bpss_pkg::ILV_W-1:0]      r_ilv;
    logic [DEPTH-1:0]                r_vld;
    logic                            r_kind;
    logic [bpss_pkg::NOW_W-1:0]      r_now;
    logic [RW-1:0]                   r_bank;
    logic [bpss_pkg::WANT_W-1:0]     r_want;
    logic [bpss_pkg::SLOT_W-1:0]     r_wait;
    logic                            r_out_valid;
    logic [bpss_pkg::BANK_OUT_W-1:0] r_bank_o;
    logic [bpss_pkg::DELAY_W-1:0]    r_delay;

    logic                            in_xfer;
    logic                            out_free;
    logic [bpss_pkg::PORT_W-1:0]     ports_raw;
    logic [bpss_pkg::PORT_W-1:0]     ports_eff;
    logic                            ports_one;
    logic [bpss_pkg::LAT_W-1:0]      lat;
    logic [bpss_pkg::ILV_W-1:0]      ilv_eff;
    logic [AW-1:0]                   maddr;
    logic [bpss_pkg::SLOT_W-1:0]     mem_rdata;
    logic [bpss_pkg::SLOT_W-1:0]     slot;
    logic [bpss_pkg::SLOT_W-1:0]     want48;
    logic                            fresh;
    logic [bpss_pkg::SLOT_W-1:0]     diff;
    logic [bpss_pkg::SLOT_W-1:0]     slot_inc;
    logic                            mem_we;
    logic                            mem_re;
    logic [bpss_pkg::SLOT_W-1:0]     mem_wdata;
    logic [bpss_pkg::SLOT_W:0]       sum;
    logic [7:0]                      bank_ext;
    bpss_pkg::t_div_req              div_req;
    bpss_pkg::t_div_rsp              div_rsp;
    logic [RW-1:0]                   div_res;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign ports_raw = r_kind ? r_wr_ports : r_rd_ports;
    assign ports_eff = (ports_raw == '0) ? {{(bpss_pkg::PORT_W-1){1'b0}}, 1'b1} : ports_raw;
    assign ports_one = (ports_eff == {{(bpss_pkg::PORT_W-1){1'b0}}, 1'b1});
    assign lat       = r_kind ? r_wr_lat : r_rd_lat;
    assign ilv_eff   = (r_ilv == '0) ? {{(bpss_pkg::ILV_W-1){1'b0}}, 1'b1} : r_ilv;

    assign maddr     = {r_kind, r_bank};
    assign slot      = r_vld[maddr] ? mem_rdata : '0;
    assign want48    = {{(bpss_pkg::SLOT_W-bpss_pkg::WANT_W){1'b0}}, r_want};
    assign fresh     = (slot < want48);
    assign diff      = slot - want48;
    assign slot_inc  = (slot == bpss_pkg::SLOT_MAX) ? slot : slot + 1'b1;
    assign mem_we    = (r_state == S_RMW);
    assign mem_wdata = fresh ? want48 : slot_inc;
    assign mem_re    = (r_state == S_BANK) && div_rsp.done;

    assign sum = {1'b0, r_wait} + {{(bpss_pkg::SLOT_W+1-bpss_pkg::LAT_W){1'b0}}, lat};

    always_comb begin
        div_req = '0;
        if (r_state == S_IDLE) begin
            div_req.start    = in_xfer;
            div_req.dividend = {i_addr, {(bpss_pkg::SLOT_W-bpss_pkg::ADDR_W){1'b0}}};
            div_req.divisor  = ilv_eff;
            div_req.pairs    = bpss_pkg::DIV_ADDR_PAIRS;
        end else begin
            div_req.start    = (r_state == S_RMW) && !fresh && !ports_one;
            div_req.dividend = diff;
            div_req.divisor  = {{(bpss_pkg::ILV_W-bpss_pkg::PORT_W){1'b0}}, ports_eff};
            div_req.pairs    = bpss_pkg::DIV_WAIT_PAIRS;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_BANK;
                end
            end
            S_BANK: begin
                if (div_rsp.done) begin
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                n_state = (fresh || ports_one) ? S_OUT : S_WDIV;
            end
            S_WDIV: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_ports  <= {{(bpss_pkg::PORT_W-1){1'b0}}, 1'b1};
            r_wr_ports  <= {{(bpss_pkg::PORT_W-1){1'b0}}, 1'b1};
            r_rd_lat    <= {{(bpss_pkg::LAT_W-1){1'b0}}, 1'b1};
            r_wr_lat    <= {{(bpss_pkg::LAT_W-1){1'b0}}, 1'b1};
            r_ilv       <= {{(bpss_pkg::ILV_W-1){1'b0}}, 1'b1};
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bpss_pkg::CFG_RD_PORTS: r_rd_ports <= i_cfg_data[bpss_pkg::PORT_W-1:0];
                    bpss_pkg::CFG_WR_PORTS: r_wr_ports <= i_cfg_data[bpss_pkg::PORT_W-1:0];
                    bpss_pkg::CFG_RD_LAT:   r_rd_lat   <= i_cfg_data[bpss_pkg::LAT_W-1:0];
                    bpss_pkg::CFG_WR_LAT:   r_wr_lat   <= i_cfg_data[bpss_pkg::LAT_W-1:0];
                    bpss_pkg::CFG_ILV:      r_ilv      <= i_cfg_data[bpss_pkg::ILV_W-1:0];
                    default: ;
                endcase
            end
            if (mem_we) begin
                r_vld[maddr] <= 1'b1;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_kind <= i_kind;
            r_now  <= i_now;
        end
        if (r_state == S_BANK) begin
            r_want <= {{(bpss_pkg::WANT_W-bpss_pkg::PORT_W){1'b0}}, ports_eff}
                    * {{(bpss_pkg::WANT_W-bpss_pkg::NOW_W){1'b0}}, r_now};
            if (div_rsp.done) begin
                r_bank <= div_res;
            end
        end
        if (r_state == S_RMW) begin
            r_wait <= fresh ? '0 : diff;
        end
        if ((r_state == S_WDIV) && div_rsp.done) begin
            r_wait <= div_rsp.quot;
        end
        if ((r_state == S_OUT) && out_free) begin
            r_bank_o <= bank_ext[bpss_pkg::BANK_OUT_W-1:0];
            r_delay  <= (sum > {{(bpss_pkg::SLOT_W+1-bpss_pkg::DELAY_W){1'b0}},
                                bpss_pkg::DELAY_MAX})
                        ? bpss_pkg::DELAY_MAX : sum[bpss_pkg::DELAY_W-1:0];
        end
    end

    assign bank_ext = {{(8-RW){1'b0}}, r_bank};

    bpss_div #(
        .BANKS (BANKS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (div_req),
        .o_rsp     (div_rsp),
        .o_residue (div_res)
    );

    bpss_ram #(
        .WIDTH (bpss_pkg::SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (maddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr ({r_kind, div_res}),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_bank_index = r_bank_o;
    assign o_delay      = r_delay;

    a_xfer_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_BANK))
        else $error("input transfer did not start the bank division");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("result registered outside the output state");

    a_wait_div_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WDIV) |-> !ports_one)
        else $error("wait division entered with a single port");

    a_div_idle_at_rmw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |-> !div_rsp.busy)
        else $error("divider still busy during slot update");

endmodule

/* rtl/core/bpss_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bpss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/bpss_div.sv */
// Radix-4 restoring divider with a running residue of the quotient modulo BANKS.
module bpss_div #(
    parameter int BANKS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  bpss_pkg::t_div_req                     i_req,
    output bpss_pkg::t_div_rsp                     o_rsp,
    output logic [((BANKS > 1) ? $clog2(BANKS) : 1)-1:0] o_residue
);

    localparam int RW = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam logic [RW:0] BANKS_C = (RW + 1)'(BANKS);

    logic                           r_busy;
    logic                           r_done;
    logic [bpss_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [bpss_pkg::SLOT_W-1:0]    r_dvd;
    logic [bpss_pkg::SLOT_W-1:0]    r_quo;
    logic [bpss_pkg::ILV_W-1:0]     r_rem;
    logic [bpss_pkg::ILV_W-1:0]     r_div;
    logic [RW-1:0]                  r_res;

    logic [bpss_pkg::SLOT_W-1:0]    n_dvd;
    logic [bpss_pkg::SLOT_W-1:0]    n_quo;
    logic [bpss_pkg::ILV_W-1:0]     n_rem;
    logic [RW-1:0]                  n_res;

    always_comb begin
        logic [bpss_pkg::ILV_W:0] t;
        logic [RW:0]              rr;
        logic                     q;
        n_dvd = r_dvd;
        n_quo = r_quo;
        n_rem = r_rem;
        n_res = r_res;
        for (int j = 0; j < 2; j++) begin
            t     = {n_rem, n_dvd[bpss_pkg::SLOT_W-1]};
            n_dvd = {n_dvd[bpss_pkg::SLOT_W-2:0], 1'b0};
            q     = (t >= {1'b0, r_div});
            if (q) begin
                t = t - {1'b0, r_div};
            end
            n_rem = t[bpss_pkg::ILV_W-1:0];
            n_quo = {n_quo[bpss_pkg::SLOT_W-2:0], q};
            rr    = {n_res, q};
            if (rr >= BANKS_C) begin
                rr = rr - BANKS_C;
            end
            n_res = rr[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.pairs;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == {{(bpss_pkg::DIV_CNT_W-1){1'b0}}, 1'b1}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_div <= i_req.divisor;
            r_quo <= '0;
            r_rem <= '0;
            r_res <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_res <= n_res;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_residue  = r_res;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider flagged done while still busy");

    a_busy_has_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("divider busy with no steps left");

endmodule

/* tb/banked_port_slot_scheduler_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the banked port slot scheduler: bank and delay per access.
module banked_port_slot_scheduler_test;

    localparam int ADDR_W     = bpss_pkg::ADDR_W;
    localparam int NOW_W      = bpss_pkg::NOW_W;
    localparam int SLOT_W     = bpss_pkg::SLOT_W;
    localparam int DELAY_W    = bpss_pkg::DELAY_W;
    localparam int PORT_W     = bpss_pkg::PORT_W;
    localparam int LAT_W      = bpss_pkg::LAT_W;
    localparam int ILV_W      = bpss_pkg::ILV_W;
    localparam int BANK_OUT_W = bpss_pkg::BANK_OUT_W;
    localparam int CFG_IDX_W  = bpss_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = bpss_pkg::CFG_DATA_W;

    localparam int BANKS        = 16;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int IDLE_SLACK   = 60;
    localparam int HOLD_OFF_LEN = 400;
    localparam int REPORT_CAP   = 200;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 150;

    localparam logic ACC_READ  = 1'b0;
    localparam logic ACC_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    localparam logic [NOW_W-1:0]  NOW_LAST  = '1;
    localparam logic [ADDR_W-1:0] ADDR_LAST = '1;
    localparam logic [63:0] CATCH_UP_CEIL = 64'd1 << 38;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] addr;
        logic [NOW_W-1:0]  now;
    } t_access;

    typedef struct packed {
        logic [BANK_OUT_W-1:0] bank;
        logic [DELAY_W-1:0]    delay;
    } t_grant;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_kind     = 1'b0;
    logic [ADDR_W-1:0]     i_addr     = '0;
    logic [NOW_W-1:0]      i_now      = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [BANK_OUT_W-1:0] o_bank_index;
    logic [DELAY_W-1:0]    o_delay;

    banked_port_slot_scheduler #(
        .BANKS(BANKS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_addr      (i_addr),
        .i_now       (i_now),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_bank_index(o_bank_index),
        .o_delay     (o_delay)
    );

    always #5 i_clk = ~i_clk;

    logic [PORT_W-1:0] rd_ports_cfg = PORT_W'(1);
    logic [PORT_W-1:0] wr_ports_cfg = PORT_W'(1);
    logic [LAT_W-1:0]  rd_lat_cfg   = LAT_W'(1);
    logic [LAT_W-1:0]  wr_lat_cfg   = LAT_W'(1);
    logic [ILV_W-1:0]  ilv_cfg      = ILV_W'(1);
    logic [SLOT_W-1:0] rd_slot [BANKS];
    logic [SLOT_W-1:0] wr_slot [BANKS];

    t_access pending_accesses[$];
    t_grant  due_grants[$];
    t_access offered;
    logic [ADDR_W-1:0] hot_addr [4];
    logic [NOW_W-1:0]  time_base = '0;

    int  mismatch_count  = 0;
    int  results_seen    = 0;
    int  reads_sent      = 0;
    int  writes_sent     = 0;
    int  queued_results  = 0;
    int  saturated_count = 0;
    int  settings_count  = 0;
    int  cycle_count     = 0;
    int  send_gap        = 0;
    int  send_calm       = 0;
    int  recv_left       = 0;
    int  recv_calm       = 0;
    int  hold_off_left   = 0;
    bit  hold_off_taken  = 1'b0;
    bit  hold_off_req    = 1'b0;
    bit  sender_eager    = 1'b0;

    function automatic t_grant schedule_access(input t_access acc);
        logic [63:0] divisor;
        logic [63:0] bank;
        logic [63:0] ports;
        logic [63:0] slot;
        logic [63:0] want;
        logic [63:0] queued;
        logic [63:0] total;
        t_grant g;
        divisor = (ilv_cfg == '0) ? 64'd1 : 64'(ilv_cfg);
        bank = (64'(acc.addr) / divisor) % 64'(BANKS);
        ports = (acc.kind == ACC_WRITE) ? 64'(wr_ports_cfg) : 64'(rd_ports_cfg);
        if (ports == 64'd0) ports = 64'd1;
        slot = (acc.kind == ACC_WRITE) ? 64'(wr_slot[bank]) : 64'(rd_slot[bank]);
        want = ports * 64'(acc.now);
        if (slot < want) begin
            queued = 64'd0;
            slot = want;
        end else begin
            queued = (slot - want) / ports;
            if (slot < 64'(bpss_pkg::SLOT_MAX)) slot = slot + 64'd1;
        end
        if (acc.kind == ACC_WRITE) begin
            wr_slot[bank] = slot[SLOT_W-1:0];
            total = queued + 64'(wr_lat_cfg);
        end else begin
            rd_slot[bank] = slot[SLOT_W-1:0];
            total = queued + 64'(rd_lat_cfg);
        end
        if (queued != 64'd0) queued_results++;
        if (total > 64'(bpss_pkg::DELAY_MAX)) saturated_count++;
        g.bank = bank[BANK_OUT_W-1:0];
        g.delay = (total > 64'(bpss_pkg::DELAY_MAX)) ? bpss_pkg::DELAY_MAX
                                                     : total[DELAY_W-1:0];
        return g;
    endfunction

    function automatic logic [NOW_W-1:0] catch_up_time(input logic [NOW_W-1:0] from);
        logic [63:0] rp;
        logic [63:0] wp;
        logic [63:0] need;
        logic [63:0] cand;
        rp = (rd_ports_cfg == '0) ? 64'd1 : 64'(rd_ports_cfg);
        wp = (wr_ports_cfg == '0) ? 64'd1 : 64'(wr_ports_cfg);
        need = 64'(from);
        for (int b = 0; b < BANKS; b++) begin
            cand = 64'(rd_slot[b]) / rp + 64'd1;
            if (cand < CATCH_UP_CEIL && cand > need) need = cand;
            cand = 64'(wr_slot[b]) / wp + 64'd1;
            if (cand < CATCH_UP_CEIL && cand > need) need = cand;
        end
        return need[NOW_W-1:0] + NOW_W'($urandom_range(0, 3));
    endfunction

    function automatic int draw_idle(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic t_access random_access(input bit wild);
        t_access acc;
        int roll;
        acc.kind = 1'($urandom);
        acc.addr = ($urandom_range(0, 99) < 45) ? hot_addr[$urandom_range(0, 3)]
                                                : ADDR_W'($urandom);
        roll = $urandom_range(0, 99);
        if (wild && roll >= 96) begin
            acc.now = {8'($urandom), 32'($urandom)};
        end else if (roll >= 91 && time_base >= 64) begin
            acc.now = time_base - NOW_W'($urandom_range(0, 64));
        end else begin
            roll = $urandom_range(0, 19);
            if (roll >= 19) time_base = time_base + NOW_W'($urandom_range(2, 40));
            else if (roll >= 14) time_base = time_base + NOW_W'(1);
            acc.now = time_base;
        end
        return acc;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
            $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bpss_pkg::CFG_RD_PORTS: rd_ports_cfg = data[PORT_W-1:0];
            bpss_pkg::CFG_WR_PORTS: wr_ports_cfg = data[PORT_W-1:0];
            bpss_pkg::CFG_RD_LAT:   rd_lat_cfg   = data[LAT_W-1:0];
            bpss_pkg::CFG_WR_LAT:   wr_lat_cfg   = data[LAT_W-1:0];
            bpss_pkg::CFG_ILV:      ilv_cfg      = data[ILV_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_access(input logic kind, input logic [ADDR_W-1:0] addr,
                                input logic [NOW_W-1:0] now);
        t_access acc;
        acc.kind = kind;
        acc.addr = addr;
        acc.now  = now;
        pending_accesses.insert(pending_accesses.size(), acc);
    endtask

    // wait out every outstanding transfer, then give the block time to go idle
    task automatic drain();
        @(negedge i_clk);
        while (pending_accesses.size() != 0 || i_in_valid || due_grants.size() != 0)
            @(negedge i_clk);
        repeat (IDLE_SLACK) @(posedge i_clk);
    endtask

    function automatic logic [PORT_W-1:0] pick_ports();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return PORT_W'(1);
            2: return PORT_W'(16);
            3: return '1;
            default: return PORT_W'($urandom_range(2, 30));
        endcase
    endfunction

    function automatic logic [LAT_W-1:0] pick_latency();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return LAT_W'($urandom);
        endcase
    endfunction

    function automatic logic [ILV_W-1:0] pick_interleave();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ILV_W'(1);
            2: return '1;
            3: return ILV_W'(1) << $urandom_range(1, 15);
            default: return ILV_W'($urandom);
        endcase
    endfunction

    task automatic program_phase(input int phase);
        logic [PORT_W-1:0] rp;
        logic [PORT_W-1:0] wp;
        logic [LAT_W-1:0]  rl;
        logic [LAT_W-1:0]  wl;
        logic [ILV_W-1:0]  il;
        case (phase)
            0: begin
                rp = PORT_W'(1); wp = PORT_W'(1); rl = '0; wl = '0; il = ILV_W'(1);
            end
            1: begin
                rp = '1; wp = PORT_W'(16); rl = '1; wl = '1; il = '1;
            end
            2: begin
                rp = '0; wp = '0; rl = pick_latency(); wl = pick_latency(); il = '0;
            end
            default: begin
                rp = pick_ports(); wp = pick_ports();
                rl = pick_latency(); wl = pick_latency(); il = pick_interleave();
            end
        endcase
        write_reg(bpss_pkg::CFG_RD_PORTS, {11'($urandom), rp});
        write_reg(bpss_pkg::CFG_WR_PORTS, {11'($urandom), wp});
        write_reg(bpss_pkg::CFG_RD_LAT, {8'($urandom), rl});
        write_reg(bpss_pkg::CFG_WR_LAT, {8'($urandom), wl});
        write_reg(bpss_pkg::CFG_ILV, il);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)),
                      CFG_DATA_W'($urandom));
        settings_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                due_grants.insert(due_grants.size(), schedule_access(offered));
                if (offered.kind == ACC_WRITE) writes_sent++;
                else reads_sent++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_accesses.size() != 0) begin
                    offered = pending_accesses.pop_front();
                    i_kind     <= offered.kind;
                    i_addr     <= offered.addr;
                    i_now      <= offered.now;
                    i_in_valid <= 1'b1;
                    send_gap = sender_eager ? 0 : draw_idle(send_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off_left  <= 0;
            hold_off_taken <= 1'b0;
        end else if (hold_off_req && !hold_off_taken) begin
            hold_off_left  <= HOLD_OFF_LEN;
            hold_off_taken <= 1'b1;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    always @(posedge i_clk) begin
        t_grant head;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (due_grants.size() == 0) begin
                    report_mismatch("result with no access outstanding", 64'(o_delay),
                                    64'd0);
                end else begin
                    head = due_grants.pop_front();
                    if (o_bank_index !== head.bank)
                        report_mismatch($sformatf("bank_index of result %0d", results_seen),
                                        64'(o_bank_index), 64'(head.bank));
                    if (o_delay !== head.delay)
                        report_mismatch($sformatf("delay of result %0d", results_seen),
                                        64'(o_delay), 64'(head.delay));
                end
                recv_left = draw_idle(recv_calm);
            end else if (o_out_valid && recv_left > 0) begin
                recv_left--;
            end
            i_out_stall <= (hold_off_left > 0) || (recv_left > 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, due_grants.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int b = 0; b < BANKS; b++) begin
            rd_slot[b] = '0;
            wr_slot[b] = '0;
        end
        for (int h = 0; h < 4; h++) hot_addr[h] = ADDR_W'($urandom);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: back-to-back hits on one bank queue up
        @(negedge i_clk);
        queue_access(ACC_READ, '0, '0);
        queue_access(ACC_READ, '0, '0);
        queue_access(ACC_READ, ADDR_W'(16), '0);
        queue_access(ACC_WRITE, ADDR_LAST, '0);
        queue_access(ACC_WRITE, ADDR_LAST, NOW_LAST);
        queue_access(ACC_WRITE, ADDR_LAST, NOW_LAST);
        queue_access(ACC_READ, ADDR_W'(5), NOW_W'(3));
        queue_access(ACC_READ, ADDR_W'(32'h8000_0000), NOW_W'(1));
        drain();

        // zero ports and zero interleave act as one; ports above sixteen as written
        write_reg(bpss_pkg::CFG_RD_PORTS, 16'hFFE0);
        write_reg(bpss_pkg::CFG_WR_PORTS, 16'h001F);
        write_reg(bpss_pkg::CFG_RD_LAT, 16'h00FF);
        write_reg(bpss_pkg::CFG_WR_LAT, 16'hFF00);
        write_reg(bpss_pkg::CFG_ILV, 16'h0000);
        write_reg(CFG_UNMAPPED_LO, 16'hFFFF);
        write_reg(CFG_UNMAPPED_HI, 16'h0000);
        settings_count++;
        @(negedge i_clk);
        repeat (3) queue_access(ACC_READ, ADDR_W'(7), NOW_W'(10));
        repeat (3) queue_access(ACC_WRITE, ADDR_W'(32'h1234_5678), NOW_W'(100));
        queue_access(ACC_READ, ADDR_LAST, NOW_W'(20));
        drain();

        write_reg(bpss_pkg::CFG_ILV, 16'hFFFF);
        write_reg(bpss_pkg::CFG_RD_PORTS, 16'h0011);
        settings_count++;
        @(negedge i_clk);
        queue_access(ACC_READ, ADDR_LAST, '0);
        queue_access(ACC_READ, ADDR_LAST, NOW_W'(40));
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            program_phase(phase);
            @(negedge i_clk);
            time_base = catch_up_time(time_base);
            if (phase % 4 == 3) time_base = time_base + NOW_W'({4'($urandom), 32'($urandom)});
            if ($urandom_range(0, 1) == 0)
                for (int h = 0; h < 4; h++) hot_addr[h] = ADDR_W'($urandom);
            // fill the block while the result side holds off
            if (phase == 4) begin
                sender_eager = 1'b1;
                hold_off_req <= 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_accesses.insert(pending_accesses.size(),
                                        random_access(phase == PHASES - 1));
            drain();
            sender_eager = 1'b0;
        end

        // slot far ahead of the requested time: wait plus latency saturates
        write_reg(bpss_pkg::CFG_ILV, 16'h0001);
        write_reg(bpss_pkg::CFG_RD_PORTS, 16'h001F);
        write_reg(bpss_pkg::CFG_RD_LAT, 16'h00FF);
        @(negedge i_clk);
        queue_access(ACC_READ, '0, NOW_LAST);
        drain();
        write_reg(bpss_pkg::CFG_RD_PORTS, 16'h0001);
        settings_count++;
        @(negedge i_clk);
        queue_access(ACC_READ, '0, '0);
        queue_access(ACC_READ, ADDR_W'(16), '0);
        drain();

        if (due_grants.size() != 0)
            report_mismatch("results never delivered", 64'd0, 64'(due_grants.size()));
        $display("Covered %0d reads and %0d writes over %0d register settings, %0d results",
                 reads_sent, writes_sent, settings_count, results_seen);
        $display("%0d accesses queued behind a busy bank, %0d delays saturated, %0d mismatches",
                 queued_results, saturated_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
